>>> rtl/sit_pkg.sv
`timescale 1ns / 1ps

package sit_pkg;

  // Restoring divider: quotient bits resolved in each divider stage.
  localparam int unsigned SIT_DIV_BPS = 4;

  // Fraction bits of Q16.16.
  localparam int unsigned SIT_QB = 16;
  // Quotient bits of the slope divide and of the crossing-x divide.
  localparam int unsigned SIT_SLOPE_QW = 32;
  localparam int unsigned SIT_X_QW = 44;
  // Intercept, intercept difference, solved x and line value widths.
  localparam int unsigned SIT_BW = 49;
  localparam int unsigned SIT_NUMW = 50;
  localparam int unsigned SIT_XW = 42;
  localparam int unsigned SIT_YW = 50;
  // Solved x magnitude saturates at 2^40.
  localparam logic [40:0] SIT_XSAT = 41'd1 << 40;

  typedef enum logic [2:0] {
    SIT_CFG_REF_X1 = 3'd0,
    SIT_CFG_REF_Y1 = 3'd1,
    SIT_CFG_REF_X2 = 3'd2,
    SIT_CFG_REF_Y2 = 3'd3,
    SIT_CFG_TOL    = 3'd4
  } sit_cfg_e;

  typedef struct packed {
    logic signed [31:0] seg_x1;
    logic signed [31:0] seg_y1;
    logic signed [31:0] seg_x2;
    logic signed [31:0] seg_y2;
    logic               final_in;
  } sit_in_t;

  typedef struct packed {
    logic               hit;
    logic               overlap;
    logic signed [31:0] cross_x;
    logic signed [31:0] cross_y;
    logic               final_out;
  } sit_out_t;

  typedef struct packed {
    logic signed [31:0] x1;
    logic signed [31:0] y1;
    logic signed [31:0] x2;
    logic signed [31:0] y2;
  } sit_seg_t;

  typedef struct packed {
    logic               vert;
    logic signed [31:0] m;
    logic signed [31:0] x1;
    logic signed [31:0] y1;
    logic signed [31:0] minx;
    logic signed [31:0] maxx;
    logic signed [31:0] miny;
    logic signed [31:0] maxy;
  } sit_line_t;

  typedef struct packed {
    logic     vert;
    logic     neg;
    logic     ovf;
    logic     last;
    sit_seg_t c;
  } sit_sl_side_t;

  typedef struct packed {
    logic both_vert;
    logic one_vert;
    logic ref_vert;
    logic par;
    logic ovl;
    logic last;
  } sit_flags_t;

  typedef struct packed {
    logic                     ovf;
    logic                     neg;
    sit_flags_t               fl;
    sit_line_t                a;
    sit_line_t                t;
    logic signed [SIT_BW-1:0] ba;
    logic signed [SIT_BW-1:0] bt;
  } sit_xside_t;

  typedef struct packed {
    sit_flags_t               fl;
    logic signed [SIT_XW-1:0] x;
    sit_line_t                a;
    sit_line_t                t;
    logic signed [SIT_BW-1:0] ba;
    logic signed [SIT_BW-1:0] bt;
  } sit_cand_t;

  // Product / 65536, truncated toward zero.
  function automatic logic signed [47:0] sit_tdiv16(logic signed [63:0] p);
    logic signed [47:0] h;
    h = p[63:16];
    if (p[63] && (p[15:0] != 16'd0)) begin
      h = h + 48'sd1;
    end
    return h;
  endfunction

endpackage

>>> rtl/sit_div.sv
`timescale 1ns / 1ps

// Pipelined unsigned restoring divider. Expects num >> QW < den; the caller
// flags larger quotients itself. QW must be a multiple of BPS.
module sit_div #(
  parameter int unsigned NW  = 48,
  parameter int unsigned DW  = 32,
  parameter int unsigned QW  = 32,
  parameter int unsigned BPS = 4,
  parameter int unsigned SW  = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [QW-1:0] quo_o,
  output logic [SW-1:0] side_o
);

  localparam int unsigned NS = QW / BPS;

  logic [NS:0]   v_q;
  logic [DW-1:0] r_q  [NS+1];
  logic [QW-1:0] q_q  [NS+1];
  logic [QW-1:0] nl_q [NS+1];
  logic [DW-1:0] d_q  [NS+1];
  logic [SW-1:0] s_q  [NS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]  <= DW'(num_i[NW-1:QW]);
      nl_q[0] <= num_i[QW-1:0];
      q_q[0]  <= '0;
      d_q[0]  <= den_i;
      s_q[0]  <= side_i;
    end
  end

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic [DW-1:0] r_d;
    logic [QW-1:0] q_d;
    logic [QW-1:0] nl_d;

    always_comb begin
      logic [DW:0] t;
      r_d  = r_q[s];
      q_d  = q_q[s];
      nl_d = nl_q[s];
      t    = '0;
      for (int j = 0; j < int'(BPS); j++) begin
        t    = {r_d, nl_d[QW-1]};
        nl_d = {nl_d[QW-2:0], 1'b0};
        if (t >= {1'b0, d_q[s]}) begin
          t   = t - {1'b0, d_q[s]};
          q_d = {q_d[QW-2:0], 1'b1};
        end else begin
          q_d = {q_d[QW-2:0], 1'b0};
        end
        r_d = t[DW-1:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s+1] <= 1'b0;
      end else if (en_i) begin
        v_q[s+1] <= v_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[s+1]  <= r_d;
        q_q[s+1]  <= q_d;
        nl_q[s+1] <= nl_d;
        d_q[s+1]  <= d_q[s];
        s_q[s+1]  <= s_q[s];
      end
    end
  end

  assign valid_o = v_q[NS];
  assign quo_o   = q_q[NS];
  assign side_o  = s_q[NS];

endmodule

>>> rtl/sit_slope.sv
`timescale 1ns / 1ps

// Slope and bounding box of the reference and the test segment, in lockstep.
module sit_slope
  import sit_pkg::*;
#(
  parameter int unsigned BPS = SIT_DIV_BPS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      valid_i,
  input  sit_seg_t  ref_i,
  input  sit_seg_t  seg_i,
  input  logic      last_i,
  output logic      valid_o,
  output sit_line_t ref_o,
  output sit_line_t seg_o,
  output logic      last_o
);

  sit_seg_t                  in_seg   [2];
  logic                      div_v    [2];
  logic [SIT_SLOPE_QW-1:0]   div_q    [2];
  sit_sl_side_t              div_side [2];
  sit_line_t                 line_q   [2];
  logic                      va_q;
  logic                      vo_q;
  logic                      lo_q;

  assign in_seg[0] = ref_i;
  assign in_seg[1] = seg_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vo_q <= div_v[1];
    end
  end

  for (genvar g = 0; g < 2; g++) begin : g_seg
    logic signed [32:0]            run_q;
    logic signed [32:0]            rise_q;
    sit_seg_t                      c_q;
    logic                          la_q;
    logic [31:0]                   n_mag;
    logic [31:0]                   d_mag;
    logic [SIT_SLOPE_QW+SIT_QB-1:0] num;
    sit_sl_side_t                  side;
    sit_line_t                     line_d;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        run_q  <= 33'($signed(in_seg[g].x2)) - 33'($signed(in_seg[g].x1));
        rise_q <= 33'($signed(in_seg[g].y2)) - 33'($signed(in_seg[g].y1));
        c_q    <= in_seg[g];
        la_q   <= (g == 1) ? last_i : 1'b0;
      end
    end

    always_comb begin
      n_mag     = rise_q[32] ? 32'(-rise_q) : 32'(rise_q);
      d_mag     = run_q[32] ? 32'(-run_q) : 32'(run_q);
      num       = {n_mag, SIT_QB'(0)};
      side.vert = (run_q == 33'sd0);
      side.neg  = rise_q[32] ^ run_q[32];
      // Quotient would need more than 32 bits.
      side.ovf  = ({SIT_QB'(0), n_mag} >= {d_mag, SIT_QB'(0)});
      side.last = la_q;
      side.c    = c_q;
    end

    sit_div #(
      .NW  (SIT_SLOPE_QW + SIT_QB),
      .DW  (32),
      .QW  (SIT_SLOPE_QW),
      .BPS (BPS),
      .SW  ($bits(sit_sl_side_t))
    ) u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en_i),
      .valid_i (va_q),
      .num_i   (num),
      .den_i   (d_mag),
      .side_i  (side),
      .valid_o (div_v[g]),
      .quo_o   (div_q[g]),
      .side_o  (div_side[g])
    );

    // Saturate to signed 32 bits and derive the bounding box.
    always_comb begin
      sit_sl_side_t sd;
      logic [31:0]  q;
      sd = div_side[g];
      q  = div_q[g];
      line_d.vert = sd.vert;
      if (sd.vert) begin
        line_d.m = 32'sd0;
      end else if (sd.ovf) begin
        line_d.m = sd.neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end else if (!sd.neg) begin
        line_d.m = q[31] ? 32'sh7fff_ffff : $signed(q);
      end else begin
        line_d.m = (q[31] && (q[30:0] != 31'd0)) ? 32'sh8000_0000 : $signed(32'(-q));
      end
      line_d.x1   = sd.c.x1;
      line_d.y1   = sd.c.y1;
      line_d.minx = ($signed(sd.c.x1) < $signed(sd.c.x2)) ? sd.c.x1 : sd.c.x2;
      line_d.maxx = ($signed(sd.c.x1) > $signed(sd.c.x2)) ? sd.c.x1 : sd.c.x2;
      line_d.miny = ($signed(sd.c.y1) < $signed(sd.c.y2)) ? sd.c.y1 : sd.c.y2;
      line_d.maxy = ($signed(sd.c.y1) > $signed(sd.c.y2)) ? sd.c.y1 : sd.c.y2;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        line_q[g] <= line_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lo_q <= div_side[1].last;
    end
  end

  assign valid_o = vo_q;
  assign ref_o   = line_q[0];
  assign seg_o   = line_q[1];
  assign last_o  = lo_q;

  // Both dividers run in lockstep.
  a_div_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_v[0] == div_v[1])
    else $error("slope dividers out of step");

endmodule

>>> rtl/sit_solve.sv
`timescale 1ns / 1ps

// Intercepts, case split and the divide that solves the crossing x.
module sit_solve
  import sit_pkg::*;
#(
  parameter int unsigned BPS = SIT_DIV_BPS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      valid_i,
  input  sit_line_t ref_i,
  input  sit_line_t seg_i,
  input  logic      last_i,
  output logic      valid_o,
  output sit_cand_t cand_o
);

  localparam int unsigned XNW = SIT_X_QW + 22;

  // Products m * x1
  logic               v1_q;
  sit_line_t          a1_q;
  sit_line_t          t1_q;
  logic               l1_q;
  logic signed [63:0] pa1_q;
  logic signed [63:0] pt1_q;

  // Intercepts
  logic                     v2_q;
  sit_line_t                a2_q;
  sit_line_t                t2_q;
  logic                     l2_q;
  logic signed [47:0]       qa;
  logic signed [47:0]       qt;
  logic signed [SIT_BW-1:0] ba2_q;
  logic signed [SIT_BW-1:0] bt2_q;

  // Case split and divide operands
  logic                       v3_q;
  sit_xside_t                 s3_q;
  sit_xside_t                 s3_d;
  logic signed [SIT_NUMW-1:0] num3_q;
  logic signed [32:0]         den3_q;

  logic [SIT_NUMW-1:0] n_mag;
  logic [31:0]         d_mag;
  logic [XNW-1:0]      div_num;
  sit_xside_t          div_side_in;

  logic                div_v;
  logic [SIT_X_QW-1:0] div_q;
  sit_xside_t          div_side;

  logic      vo_q;
  sit_cand_t cand_q;
  sit_cand_t cand_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      vo_q <= div_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a1_q  <= ref_i;
      t1_q  <= seg_i;
      l1_q  <= last_i;
      pa1_q <= $signed(ref_i.m) * $signed(ref_i.x1);
      pt1_q <= $signed(seg_i.m) * $signed(seg_i.x1);
    end
  end

  assign qa = sit_tdiv16(pa1_q);
  assign qt = sit_tdiv16(pt1_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a2_q  <= a1_q;
      t2_q  <= t1_q;
      l2_q  <= l1_q;
      ba2_q <= SIT_BW'($signed(a1_q.y1)) - SIT_BW'(qa);
      bt2_q <= SIT_BW'($signed(t1_q.y1)) - SIT_BW'(qt);
    end
  end

  always_comb begin
    s3_d              = '0;
    s3_d.a            = a2_q;
    s3_d.t            = t2_q;
    s3_d.ba           = ba2_q;
    s3_d.bt           = bt2_q;
    s3_d.fl.last      = l2_q;
    s3_d.fl.both_vert = a2_q.vert && t2_q.vert;
    s3_d.fl.one_vert  = a2_q.vert ^ t2_q.vert;
    s3_d.fl.ref_vert  = a2_q.vert;
    s3_d.fl.par       = !a2_q.vert && !t2_q.vert && (a2_q.m == t2_q.m);
    s3_d.fl.ovl       = a2_q.vert && t2_q.vert && (a2_q.x1 == t2_q.x1)
                        && !(($signed(a2_q.miny) > $signed(t2_q.maxy))
                          || ($signed(t2_q.miny) > $signed(a2_q.maxy)));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_q   <= s3_d;
      num3_q <= SIT_NUMW'(ba2_q) - SIT_NUMW'(bt2_q);
      den3_q <= 33'($signed(t2_q.m)) - 33'($signed(a2_q.m));
    end
  end

  always_comb begin
    n_mag       = num3_q[SIT_NUMW-1] ? SIT_NUMW'(-num3_q) : SIT_NUMW'(num3_q);
    d_mag       = den3_q[32] ? 32'(-den3_q) : 32'(den3_q);
    div_num     = XNW'({n_mag, SIT_QB'(0)});
    div_side_in = s3_q;
    div_side_in.neg = num3_q[SIT_NUMW-1] ^ den3_q[32];
    // Quotient at or above 2^41 saturates anyway.
    div_side_in.ovf = ({7'd0, n_mag} >= {d_mag, 25'd0});
  end

  sit_div #(
    .NW  (XNW),
    .DW  (32),
    .QW  (SIT_X_QW),
    .BPS (BPS),
    .SW  ($bits(sit_xside_t))
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (v3_q),
    .num_i   (div_num),
    .den_i   (d_mag),
    .side_i  (div_side_in),
    .valid_o (div_v),
    .quo_o   (div_q),
    .side_o  (div_side)
  );

  always_comb begin
    logic [40:0] qs;
    if (div_side.ovf || (div_q > SIT_X_QW'(SIT_XSAT))) begin
      qs = SIT_XSAT;
    end else begin
      qs = div_q[40:0];
    end
    cand_d.fl = div_side.fl;
    cand_d.a  = div_side.a;
    cand_d.t  = div_side.t;
    cand_d.ba = div_side.ba;
    cand_d.bt = div_side.bt;
    if (div_side.fl.one_vert) begin
      cand_d.x = div_side.fl.ref_vert ? SIT_XW'($signed(div_side.a.x1))
                                      : SIT_XW'($signed(div_side.t.x1));
    end else if (div_side.neg) begin
      cand_d.x = $signed(-SIT_XW'(qs));
    end else begin
      cand_d.x = $signed(SIT_XW'(qs));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cand_q <= cand_d;
    end
  end

  assign valid_o = vo_q;
  assign cand_o  = cand_q;

endmodule

>>> rtl/sit_eval.sv
`timescale 1ns / 1ps

// Line values at the candidate x and the final hit decision.
module sit_eval
  import sit_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  sit_cand_t   cand_i,
  input  logic [30:0] tol_i,
  output logic        valid_o,
  output sit_out_t    out_o
);

  logic        v1_q, v2_q, v3_q, v4_q, vo_q;
  sit_cand_t   c1_q, c2_q, c3_q, c4_q;
  logic        xa1_q, xt1_q, xa2_q, xt2_q, xa3_q, xt3_q, xa4_q, xt4_q;
  logic [31:0] x1_q, x2_q, x3_q, x4_q;

  logic signed [63:0]       pa2_q, pt2_q;
  logic signed [47:0]       qa, qt;
  logic signed [SIT_YW-1:0] ya3_q, yt3_q, ya4_q, yt4_q;
  logic signed [SIT_YW:0]   diff4_q;
  sit_out_t                 out_q, out_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      vo_q <= v4_q;
    end
  end

  // x range checks on the full-width x
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c1_q  <= cand_i;
      x1_q  <= cand_i.x[31:0];
      xa1_q <= (cand_i.x >= SIT_XW'($signed(cand_i.a.minx)))
               && (cand_i.x <= SIT_XW'($signed(cand_i.a.maxx)));
      xt1_q <= (cand_i.x >= SIT_XW'($signed(cand_i.t.minx)))
               && (cand_i.x <= SIT_XW'($signed(cand_i.t.maxx)));
    end
  end

  // m * x; only an x inside a 32-bit range can hit
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c2_q  <= c1_q;
      x2_q  <= x1_q;
      xa2_q <= xa1_q;
      xt2_q <= xt1_q;
      pa2_q <= $signed(c1_q.a.m) * $signed(x1_q);
      pt2_q <= $signed(c1_q.t.m) * $signed(x1_q);
    end
  end

  assign qa = sit_tdiv16(pa2_q);
  assign qt = sit_tdiv16(pt2_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c3_q  <= c2_q;
      x3_q  <= x2_q;
      xa3_q <= xa2_q;
      xt3_q <= xt2_q;
      ya3_q <= SIT_YW'(qa) + SIT_YW'(c2_q.ba);
      yt3_q <= SIT_YW'(qt) + SIT_YW'(c2_q.bt);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c4_q    <= c3_q;
      x4_q    <= x3_q;
      xa4_q   <= xa3_q;
      xt4_q   <= xt3_q;
      ya4_q   <= ya3_q;
      yt4_q   <= yt3_q;
      diff4_q <= (SIT_YW+1)'(ya3_q) - (SIT_YW+1)'(yt3_q);
    end
  end

  always_comb begin
    logic signed [SIT_YW-1:0] yv;
    logic signed [SIT_YW-1:0] cy;
    logic signed [SIT_YW:0]   tol;
    sit_line_t                v;
    logic                     xin;
    logic                     hit;
    tol = $signed((SIT_YW+1)'(tol_i));
    v   = c4_q.fl.ref_vert ? c4_q.a : c4_q.t;
    yv  = c4_q.fl.ref_vert ? yt4_q : ya4_q;
    xin = c4_q.fl.ref_vert ? xt4_q : xa4_q;
    if (c4_q.fl.both_vert) begin
      hit = 1'b0;
      cy  = ya4_q;
    end else if (c4_q.fl.one_vert) begin
      hit = xin && (yv >= SIT_YW'($signed(v.miny))) && (yv <= SIT_YW'($signed(v.maxy)));
      cy  = yv;
    end else begin
      hit = !c4_q.fl.par && xa4_q && xt4_q && (diff4_q <= tol) && (diff4_q >= -tol);
      cy  = ya4_q;
    end
    out_d.hit       = hit;
    out_d.overlap   = c4_q.fl.ovl;
    out_d.final_out = c4_q.fl.last;
    out_d.cross_x   = hit ? $signed(x4_q) : 32'sd0;
    if (!hit) begin
      out_d.cross_y = 32'sd0;
    end else if (cy > SIT_YW'(32'sh7fff_ffff)) begin
      out_d.cross_y = 32'sh7fff_ffff;
    end else if (cy < SIT_YW'(32'sh8000_0000)) begin
      out_d.cross_y = 32'sh8000_0000;
    end else begin
      out_d.cross_y = cy[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q <= out_d;
    end
  end

  assign valid_o = vo_q;
  assign out_o   = out_q;

endmodule

>>> rtl/segment_intersection_tester.sv
`timescale 1ns / 1ps

// Segment intersection tester. Tests every incoming segment against a
// reference segment held in configuration registers and returns one
// result per segment, in order: hit with the crossing point in signed
// Q16.16, or overlap when both segments are vertical at the same x with
// touching or overlapping y ranges. All divides truncate toward zero.
// The block takes one segment per clock unless the output stalls, and
// takes new segments before earlier ones finish. Two pipelined restoring
// dividers, the slope divide and the crossing-x divide, resolve B = 4
// quotient bits per stage by default. A stalled output freezes the whole
// pipeline, so in_stall_o follows out_stall_i while a result waits.
// Write configuration only while no segment is in flight.
module segment_intersection_tester
  import sit_pkg::*;
#(
  parameter int unsigned DIV_BPS = SIT_DIV_BPS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  sit_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output sit_out_t    out_data_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  logic signed [31:0] ref_x1_q, ref_y1_q, ref_x2_q, ref_y2_q;
  logic [30:0]        tol_q;

  logic      en;
  logic      in_valid_q;
  sit_in_t   in_q;
  sit_seg_t  ref_seg;
  sit_seg_t  test_seg;

  logic      sl_valid;
  sit_line_t sl_ref;
  sit_line_t sl_seg;
  logic      sl_last;

  logic      so_valid;
  sit_cand_t so_cand;

  // Configuration registers: indexes beyond the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_x1_q <= 32'sd0;
      ref_y1_q <= 32'sd0;
      ref_x2_q <= 32'sd0;
      ref_y2_q <= 32'sd0;
      tol_q    <= 31'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        SIT_CFG_REF_X1: ref_x1_q <= cfg_data_i;
        SIT_CFG_REF_Y1: ref_y1_q <= cfg_data_i;
        SIT_CFG_REF_X2: ref_x2_q <= cfg_data_i;
        SIT_CFG_REF_Y2: ref_y2_q <= cfg_data_i;
        SIT_CFG_TOL:    tol_q    <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // Advance every stage unless a finished result is held by the receiver.
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // Input register: capture one transfer per cycle while not stalled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (en) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      in_q <= in_data_i;
    end
  end

  assign ref_seg.x1  = ref_x1_q;
  assign ref_seg.y1  = ref_y1_q;
  assign ref_seg.x2  = ref_x2_q;
  assign ref_seg.y2  = ref_y2_q;
  assign test_seg.x1 = in_q.seg_x1;
  assign test_seg.y1 = in_q.seg_y1;
  assign test_seg.x2 = in_q.seg_x2;
  assign test_seg.y2 = in_q.seg_y2;

  // Slope, vertical flag and bounding box of both segments.
  sit_slope #(
    .BPS (DIV_BPS)
  ) u_slope (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_q),
    .ref_i   (ref_seg),
    .seg_i   (test_seg),
    .last_i  (in_q.final_in),
    .valid_o (sl_valid),
    .ref_o   (sl_ref),
    .seg_o   (sl_seg),
    .last_o  (sl_last)
  );

  // Intercepts, case split and solved crossing x.
  sit_solve #(
    .BPS (DIV_BPS)
  ) u_solve (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sl_valid),
    .ref_i   (sl_ref),
    .seg_i   (sl_seg),
    .last_i  (sl_last),
    .valid_o (so_valid),
    .cand_o  (so_cand)
  );

  // Line values, tolerance check and the output register.
  sit_eval u_eval (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (so_valid),
    .cand_i  (so_cand),
    .tol_i   (tol_q),
    .valid_o (out_valid_o),
    .out_o   (out_data_o)
  );

  a_hit_ovl_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.hit && out_data_o.overlap))
    else $error("hit and overlap both set");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.hit) |->
      (out_data_o.cross_x == 32'sd0) && (out_data_o.cross_y == 32'sd0))
    else $error("crossing point set without hit");

  a_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_valid_q)
    else $error("accepted transfer not captured");

endmodule

>>> tb/segment_intersection_checker.sv
`timescale 1ns / 1ps

module segment_intersection_checker
  import sit_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  sit_in_t     in_data_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  sit_out_t    out_data_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  output int          pending_o,
  output int          errors_o
);

  typedef struct {
    bit     vert;
    longint xv, m, b, minx, maxx, miny, maxy;
  } line_t;

  logic signed [31:0] ref_x1, ref_y1, ref_x2, ref_y2;
  logic [30:0]        tol;
  sit_out_t           crossings_q[$];

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned magn(longint v);
    return (v < 0) ? longint'(64'd0) - v : v;
  endfunction

  function automatic line_t make_line(longint x1, longint y1, longint x2, longint y2);
    line_t l;
    longint run;
    run = x2 - x1;
    l.vert = (run == 0);
    l.xv = x1;
    l.m = 0;
    l.b = 0;
    if (!l.vert) begin
      l.m = clamp32(((y2 - y1) * 65536) / run);
      l.b = y1 - (l.m * x1) / 65536;
    end
    l.minx = (x1 < x2) ? x1 : x2;
    l.maxx = (x1 > x2) ? x1 : x2;
    l.miny = (y1 < y2) ? y1 : y2;
    l.maxy = (y1 > y2) ? y1 : y2;
    return l;
  endfunction

  // Line value at x, only meaningful when x lies in the segment's x range.
  function automatic bit value_at(line_t l, longint x, output longint y);
    y = 0;
    if (x < l.minx || x > l.maxx) return 0;
    y = (l.m * x) / 65536 + l.b;
    return 1;
  endfunction

  // (num * 65536) / den toward zero, magnitude capped at 2^40.
  function automatic longint solve_x(longint num, longint den);
    longint unsigned n, d, q, q1, r;
    bit neg;
    n = magn(num);
    d = magn(den);
    neg = (num < 0) != (den < 0);
    q1 = n / d;
    r = n % d;
    if (q1 >= (64'd1 << 24)) begin
      q = 64'd1 << 40;
    end else begin
      q = q1 * 65536 + (r * 65536) / d;
      if (q > (64'd1 << 40)) q = 64'd1 << 40;
    end
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic sit_out_t predict_crossing(sit_in_t s);
    line_t a, t, v, n;
    sit_out_t o;
    bit hit, ovl;
    longint cx, cy, x, ya, yt;
    a = make_line(ref_x1, ref_y1, ref_x2, ref_y2);
    t = make_line(s.seg_x1, s.seg_y1, s.seg_x2, s.seg_y2);
    hit = 0;
    ovl = 0;
    cx = 0;
    cy = 0;
    if (a.vert && t.vert) begin
      ovl = (a.xv == t.xv) && !(a.miny > t.maxy || t.miny > a.maxy);
    end else if (a.vert || t.vert) begin
      v = a.vert ? a : t;
      n = a.vert ? t : a;
      if (value_at(n, v.xv, ya) && ya >= v.miny && ya <= v.maxy) begin
        hit = 1;
        cx = v.xv;
        cy = ya;
      end
    end else if (t.m != a.m) begin
      x = solve_x(a.b - t.b, t.m - a.m);
      if (value_at(a, x, ya) && value_at(t, x, yt) && magn(ya - yt) <= tol) begin
        hit = 1;
        cx = x;
        cy = ya;
      end
    end
    if (hit) cy = clamp32(cy);
    o.hit = hit;
    o.overlap = ovl;
    o.cross_x = cx[31:0];
    o.cross_y = cy[31:0];
    o.final_out = s.final_in;
    return o;
  endfunction

  assign pending_o = crossings_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    sit_out_t e;
    if (!rst_ni) begin
      ref_x1 = 0;
      ref_y1 = 0;
      ref_x2 = 0;
      ref_y2 = 0;
      tol = 31'd1;
      errors_o = 0;
      crossings_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          SIT_CFG_REF_X1: ref_x1 = cfg_data_i;
          SIT_CFG_REF_Y1: ref_y1 = cfg_data_i;
          SIT_CFG_REF_X2: ref_x2 = cfg_data_i;
          SIT_CFG_REF_Y2: ref_y2 = cfg_data_i;
          SIT_CFG_TOL:    tol = cfg_data_i[30:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (crossings_q.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_data_i);
          errors_o++;
        end else begin
          e = crossings_q.pop_front();
          if (out_data_i !== e) begin
            $display("%0t: mismatch expected %p actual %p", $time, e, out_data_i);
            errors_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) crossings_q.push_back(predict_crossing(in_data_i));
    end
  end

endmodule

>>> tb/segment_intersection_tester_tb.sv
`timescale 1ns / 1ps

module segment_intersection_tester_tb;
  import sit_pkg::*;

  localparam int QONE = 65536;
  localparam int WATCHDOG = 20000;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_stall;
  sit_in_t     in_data = '0;
  logic        out_valid;
  logic        out_stall = 0;
  sit_out_t    out_data;
  logic        cfg_we = 0;
  logic [2:0]  cfg_idx = '0;
  logic [31:0] cfg_data = '0;
  int          pending, errors;

  // Idle percentages of the current phase and the long receiver hold-off request.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_req = 0;
  int hold_left = 0;
  int ref_c[4];

  always #4 clk = ~clk;

  segment_intersection_tester dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  segment_intersection_checker chk (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .pending_o(pending), .errors_o(errors)
  );

  // Receiver: random stall, or a long hold-off counted here when requested.
  always @(negedge clk) begin
    if (hold_req && hold_left == 0) hold_left = 400;
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog: end the run after too many cycles with no transfer.
  always @(posedge clk) begin
    int quiet;
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
    else quiet++;
    if (quiet >= WATCHDOG) begin
      $display("status: fail");
      $finish;
    end
  end

  // Offer one segment and hold it until the transfer happens.
  task automatic send_seg(sit_in_t s);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid = 0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid = 1;
    in_data = s;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(sit_cfg_e idx, logic [31:0] val);
    cfg_we = 1;
    cfg_idx = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 0;
  endtask

  task automatic set_ref(int x1, int y1, int x2, int y2, logic [31:0] tolv);
    write_reg(SIT_CFG_REF_X1, x1);
    write_reg(SIT_CFG_REF_Y1, y1);
    write_reg(SIT_CFG_REF_X2, x2);
    write_reg(SIT_CFG_REF_Y2, y2);
    write_reg(SIT_CFG_TOL, tolv);
    ref_c = '{x1, y1, x2, y2};
  endtask

  function automatic sit_in_t mk(int x1, int y1, int x2, int y2, bit fin);
    sit_in_t s;
    s.seg_x1 = x1;
    s.seg_y1 = y1;
    s.seg_x2 = x2;
    s.seg_y2 = y2;
    s.final_in = fin;
    return s;
  endfunction

  function automatic int near_val();
    return int'($urandom_range(12 * QONE)) - 6 * QONE;
  endfunction

  // Mostly segments within six units of the origin or of the reference so that crossings happen often.
  function automatic sit_in_t rand_seg();
    sit_in_t s;
    int k;
    k = $urandom_range(9);
    s = mk(near_val(), near_val(), near_val(), near_val(), $urandom_range(1));
    case (k)
      0: s = mk($urandom, $urandom, $urandom, $urandom, $urandom_range(1));
      1: s.seg_x2 = s.seg_x1;
      2: s.seg_x1 = ref_c[0];
      3: begin
        s.seg_x1 = ref_c[0];
        s.seg_x2 = ref_c[0];
      end
      4: begin
        s.seg_x1 = ref_c[0] + near_val();
        s.seg_y1 = ref_c[1] + near_val();
        s.seg_x2 = ref_c[2] + near_val();
        s.seg_y2 = ref_c[3] + near_val();
      end
      5: begin
        s.seg_x1 = ref_c[0] - 1;
        s.seg_y1 = ref_c[3];
        s.seg_x2 = ref_c[2] + 1;
        s.seg_y2 = ref_c[1];
      end
      default: ;
    endcase
    return s;
  endfunction

  task automatic random_phase(int n, int idle, int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < n; i++) begin
      send_seg(rand_seg());
      // Mix in stretches with no idling at all.
      if (i % 60 == 30) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end else if (i % 60 == 50) begin
        send_idle_pct = idle;
        recv_stall_pct = stall;
      end
    end
    drain();
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    // Directed: reference diagonal (0,0)-(4,4).
    set_ref(0, 0, 4 * QONE, 4 * QONE, 1);
    send_seg(mk(0, 4 * QONE, 4 * QONE, 0, 0));                 // plain crossing
    send_seg(mk(2 * QONE, -QONE, 2 * QONE, 5 * QONE, 1));      // vertical test
    send_seg(mk(-QONE, 3 * QONE, 5 * QONE, 3 * QONE, 0));      // horizontal
    send_seg(mk(0, QONE, 4 * QONE, 5 * QONE, 0));              // parallel
    send_seg(mk(5 * QONE, 0, 9 * QONE, -QONE, 1));             // out of range
    send_seg(mk(QONE, QONE, QONE, QONE, 0));                   // degenerate on line
    send_seg(mk(4 * QONE, 4 * QONE, 8 * QONE, 0, 0));          // endpoint touch
    send_seg(mk(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 1));
    send_seg(mk(32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 0));
    send_seg(mk(0, 32'h80000000, 1, 32'h7fffffff, 1));         // saturated slope
    send_seg(mk(-1, 32'h7fffffff, 0, 32'h80000000, 0));
    send_seg(mk(32'hffffffff, 32'hffffffff, 32'hffffffff, 0, 1));
    send_seg(mk(3, 5 * QONE, 7, -5 * QONE, 0));                // steep near zero
    drain();

    // Directed: vertical reference at x=1, y in [0,2].
    set_ref(QONE, 0, QONE, 2 * QONE, 0);
    send_seg(mk(QONE, QONE, QONE, 3 * QONE, 0));               // overlap
    send_seg(mk(QONE, 2 * QONE, QONE, 5 * QONE, 1));           // touching ends
    send_seg(mk(QONE, 3 * QONE, QONE, 5 * QONE, 0));           // disjoint
    send_seg(mk(2 * QONE, 0, 2 * QONE, QONE, 0));              // other x
    send_seg(mk(0, 0, 2 * QONE, 2 * QONE, 1));                 // crosses vertical
    send_seg(mk(0, 3 * QONE, 2 * QONE, 5 * QONE, 0));          // misses y range
    send_seg(mk(32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1));
    drain();
    // Register indexes past the list must be ignored.
    cfg_we = 1;
    cfg_idx = 3'd5;
    cfg_data = $urandom;
    @(negedge clk);
    cfg_idx = 3'd7;
    @(negedge clk);
    cfg_we = 0;
    send_seg(mk(QONE, -QONE, QONE, 0, 0));
    drain();

    // Random phases across reference settings and idle mixes.
    set_ref(-3 * QONE, 2 * QONE, 5 * QONE, -QONE, 16);
    random_phase(190, 0, 0);
    set_ref(0, 0, 4 * QONE, 4 * QONE, 32'h7fffffff);
    random_phase(190, 56, 0);
    set_ref(QONE, -2 * QONE, QONE, 3 * QONE, 0);
    random_phase(190, 0, 56);
    set_ref(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 0);
    random_phase(190, 56, 56);
    set_ref(-5 * QONE, QONE, 6 * QONE, QONE, 1);
    random_phase(190, 18, 18);
    set_ref(2 * QONE, 2 * QONE, 2 * QONE, 2 * QONE, 8);
    random_phase(150, 18, 18);
    set_ref($urandom, $urandom, $urandom, $urandom, $urandom);
    random_phase(180, 18, 18);

    // Pressure: long receiver hold-off while segments keep coming, then
    // pause the sender until everything is back.
    set_ref(-2 * QONE, -2 * QONE, 3 * QONE, 4 * QONE, 256);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 1;
    do @(negedge clk); while (hold_left == 0);
    hold_req = 0;
    for (int i = 0; i < 100; i++) send_seg(rand_seg());
    in_valid = 0;
    while (pending != 0) @(negedge clk);
    random_phase(150, 18, 18);

    drain();
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/sit_pkg.sv
rtl/sit_div.sv
rtl/sit_slope.sv
rtl/sit_solve.sv
rtl/sit_eval.sv
rtl/segment_intersection_tester.sv
tb/segment_intersection_checker.sv
tb/segment_intersection_tester_tb.sv
